// ----- rtl/core/pms_pkg.sv -----
// shared types and codes for the packed monochrome pixel store
package pms_pkg;

    // byte index width before range check: (511/8)*511 + 511 stays below 2**16
    localparam int BIDX_W = 16;

    typedef logic [BIDX_W-1:0] bidx_t;

    typedef enum logic [1:0] {
        ARR_ROW_H  = 2'd0,
        ARR_COL_V  = 2'd1,
        ARR_VCOL_H = 2'd2,
        ARR_PAGE_V = 2'd3
    } arr_t;

    typedef enum logic [1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_ARRANGEMENT  = 2'd2,
        CFG_MSB_FIRST    = 2'd3
    } cfg_idx_t;

    localparam logic CMD_SET  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic [7:0] MASK_MSB = 8'h80;
    localparam logic [7:0] MASK_LSB = 8'h01;

    localparam logic [8:0] RST_IMAGE_WIDTH  = 9'd128;
    localparam logic [8:0] RST_IMAGE_HEIGHT = 9'd64;
    localparam arr_t       RST_ARRANGEMENT  = ARR_PAGE_V;
    localparam logic       RST_MSB_FIRST    = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR = 2'b01,
        ST_RUN   = 2'b10
    } state_t;

    // outcome of mapping one coordinate pair
    typedef struct packed {
        logic       stored;
        logic       in_image;
        logic [7:0] mask;
    } loc_t;

endpackage

// ----- rtl/core/packed_mono_pixel_store.sv -----
// top level of the packed monochrome pixel store
//
// A one-bit-per-pixel image held in a byte ram. A set or read command is taken on
// every clock edge where start is high and busy is low, so one command per cycle
// is sustained; the limit is the single read and single write port of the ram,
// with the byte just written forwarded to a following command on the same byte.
// A read gives its result with done high for one cycle, registered through s1,
// s2 and the rmw result register; a set gives no result. After reset busy stays
// high while a clearing pass zeroes all STORE_BYTES bytes one byte a cycle.
// Configuration writes are accepted at any time but must only be made while no
// command is in flight.
module packed_mono_pixel_store #(
    parameter int STORE_BYTES = 8192
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic       command,
    input  logic [8:0] column,
    input  logic [8:0] row,
    output logic       done,
    output logic       pixel,
    output logic       in_range,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [8:0] cfg_data
);

    import pms_pkg::*;

    localparam int AW = $clog2(STORE_BYTES);
    localparam logic [AW-1:0] CLR_LAST = AW'(STORE_BYTES - 1);

    state_t        state_reg;
    state_t        state_next;
    logic [AW-1:0] clr_addr_reg;
    logic [AW-1:0] clr_addr_next;

    logic [8:0]    image_width_reg;
    logic [8:0]    image_height_reg;
    arr_t          arrangement_reg;
    logic          msb_first_reg;

    logic          accept;
    logic          s1_valid_reg;
    logic          s1_cmd_reg;
    logic [8:0]    s1_col_reg;
    logic [8:0]    s1_row_reg;
    logic          s2_valid_reg;
    logic          s2_cmd_reg;
    logic [AW-1:0] s2_addr_reg;
    loc_t          s2_loc_reg;

    logic [AW-1:0] s1_addr;
    loc_t          s1_loc;

    logic          rmw_we;
    logic [AW-1:0] rmw_waddr;
    logic [7:0]    rmw_wdata;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic [7:0]    ram_rdata;

    assign busy      = (state_reg == ST_CLEAR);
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;

    // clearing sweep after reset
    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == CLR_LAST)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                state_next = ST_RUN;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= RST_IMAGE_WIDTH;
            image_height_reg <= RST_IMAGE_HEIGHT;
            arrangement_reg  <= RST_ARRANGEMENT;
            msb_first_reg    <= RST_MSB_FIRST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_data;
                CFG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                CFG_ARRANGEMENT:  arrangement_reg  <= arr_t'(cfg_data[1:0]);
                CFG_MSB_FIRST:    msb_first_reg    <= cfg_data[0];
                default:          msb_first_reg    <= msb_first_reg;
            endcase
        end
    end

    // command pipeline: capture, locate and read, modify and write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_cmd_reg  <= command;
        s1_col_reg  <= column;
        s1_row_reg  <= row;
        s2_cmd_reg  <= s1_cmd_reg;
        s2_addr_reg <= s1_addr;
        s2_loc_reg  <= s1_loc;
    end

    pms_locate #(
        .STORE_BYTES (STORE_BYTES)
    ) u_locate (
        .image_width  (image_width_reg),
        .image_height (image_height_reg),
        .arrangement  (arrangement_reg),
        .msb_first    (msb_first_reg),
        .column       (s1_col_reg),
        .row          (s1_row_reg),
        .addr         (s1_addr),
        .loc          (s1_loc)
    );

    pms_rmw #(
        .STORE_BYTES (STORE_BYTES)
    ) u_rmw (
        .clk      (clk),
        .rst_n    (rst_n),
        .valid    (s2_valid_reg),
        .command  (s2_cmd_reg),
        .addr     (s2_addr_reg),
        .loc      (s2_loc_reg),
        .rdata    (ram_rdata),
        .we       (rmw_we),
        .waddr    (rmw_waddr),
        .wdata    (rmw_wdata),
        .done     (done),
        .pixel    (pixel),
        .in_range (in_range)
    );

    assign ram_we    = busy || rmw_we;
    assign ram_waddr = busy ? clr_addr_reg : rmw_waddr;
    assign ram_wdata = busy ? 8'd0 : rmw_wdata;

    pms_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (s1_addr),
        .rdata (ram_rdata)
    );

`ifndef SYNTHESIS
    a_done_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(s1_valid_reg && (s1_cmd_reg == CMD_READ), 2))
        else $error("read result without a read beat");

    a_idle_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> (!s1_valid_reg && !s2_valid_reg && !rmw_we))
        else $error("command in flight during clearing pass");

    a_pixel_needs_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !in_range) |-> !pixel)
        else $error("pixel set outside the image");

    a_clear_ends_at_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> ($past(clr_addr_reg) == CLR_LAST))
        else $error("clearing pass ended early");
`endif

endmodule

// ----- rtl/core/pms_ram.sv -----
// generic single write port ram with registered read
module pms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/pms_locate.sv -----
// maps a column and row to a byte address and bit mask for the active arrangement
module pms_locate #(
    parameter int STORE_BYTES = 8192
) (
    input  logic [8:0]                     image_width,
    input  logic [8:0]                     image_height,
    input  pms_pkg::arr_t                  arrangement,
    input  logic                           msb_first,
    input  logic [8:0]                     column,
    input  logic [8:0]                     row,
    output logic [$clog2(STORE_BYTES)-1:0] addr,
    output pms_pkg::loc_t                  loc
);

    import pms_pkg::*;

    localparam int AW = $clog2(STORE_BYTES);
    localparam logic [31:0] STORE_LIM = 32'(STORE_BYTES);

    bidx_t      mul_a;
    bidx_t      mul_b;
    bidx_t      add_c;
    bidx_t      idx;
    logic [2:0] pos;
    logic       in_image;

    // one shared multiplier, operands chosen by arrangement
    always_comb
    begin
        case (arrangement)
            ARR_ROW_H:
            begin
                mul_a = {10'd0, image_width[8:3]};
                mul_b = {7'd0, row};
                add_c = {10'd0, column[8:3]};
                pos   = column[2:0];
            end
            ARR_COL_V:
            begin
                mul_a = {10'd0, image_height[8:3]};
                mul_b = {7'd0, column};
                add_c = {10'd0, row[8:3]};
                pos   = row[2:0];
            end
            ARR_VCOL_H:
            begin
                mul_a = {10'd0, column[8:3]};
                mul_b = {7'd0, image_height};
                add_c = {7'd0, row};
                pos   = column[2:0];
            end
            default:
            begin
                mul_a = {10'd0, row[8:3]};
                mul_b = {7'd0, image_width};
                add_c = {7'd0, column};
                pos   = row[2:0];
            end
        endcase
    end

    assign idx      = mul_a * mul_b + add_c;
    assign in_image = (column < image_width) && (row < image_height);
    assign addr     = AW'(idx);

    always_comb
    begin
        loc.in_image = in_image;
        loc.stored   = in_image && ({16'd0, idx} < STORE_LIM);
        loc.mask     = msb_first ? (MASK_MSB >> pos) : (MASK_LSB << pos);
    end

endmodule

// ----- rtl/core/pms_rmw.sv -----
// read-modify-write stage with write forwarding and the registered read result
module pms_rmw #(
    parameter int STORE_BYTES = 8192
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           valid,
    input  logic                           command,
    input  logic [$clog2(STORE_BYTES)-1:0] addr,
    input  pms_pkg::loc_t                  loc,
    input  logic [7:0]                     rdata,
    output logic                           we,
    output logic [$clog2(STORE_BYTES)-1:0] waddr,
    output logic [7:0]                     wdata,
    output logic                           done,
    output logic                           pixel,
    output logic                           in_range
);

    import pms_pkg::*;

    localparam int AW = $clog2(STORE_BYTES);

    logic          fwd_valid_reg;
    logic [AW-1:0] fwd_addr_reg;
    logic [7:0]    fwd_data_reg;
    logic [7:0]    cur_byte;
    logic          done_reg;
    logic          done_next;
    logic          pixel_reg;
    logic          pixel_next;
    logic          in_range_reg;

    // the ram read was issued in the same cycle as the previous write
    assign cur_byte = (fwd_valid_reg && (fwd_addr_reg == addr)) ? fwd_data_reg : rdata;

    assign we    = valid && (command == CMD_SET) && loc.stored;
    assign waddr = addr;
    assign wdata = cur_byte | loc.mask;

    assign done_next  = valid && (command == CMD_READ);
    assign pixel_next = loc.stored && ((cur_byte & loc.mask) != 8'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            fwd_valid_reg <= we;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_addr_reg <= waddr;
        fwd_data_reg <= wdata;
        pixel_reg    <= pixel_next;
        in_range_reg <= loc.in_image;
    end

    assign done     = done_reg;
    assign pixel    = pixel_reg;
    assign in_range = in_range_reg;

endmodule
